// ===== src/bpsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Buffer pool slot manager package
// Shared types and constants for the slot manager controller and datapath.
// ----------------------------------------------------------------------------
package bpsm_pkg;

   localparam logic [2:0] OP_LOAD      = 3'd0;
   localparam logic [2:0] OP_TOUCH     = 3'd1;
   localparam logic [2:0] OP_SET_DIRTY = 3'd2;
   localparam logic [2:0] OP_SET_LOCK  = 3'd3;
   localparam logic [2:0] OP_CLR_LOCK  = 3'd4;
   localparam logic [2:0] OP_DROP      = 3'd5;
   localparam logic [2:0] OP_ALLOC     = 3'd6;

   localparam logic [7:0] COUNT_LIMIT_RESET = 8'd100;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [15:0] file_id;
      logic [23:0] block_offset;
      logic [3:0]  slot;
      logic        use_exclude;
   } req_type;

   typedef struct packed {
      logic [3:0]  slot_out;
      logic        hit;
      logic        status;
      logic        writeback;
      logic [15:0] wb_file_id;
      logic [23:0] wb_block_offset;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] file_tag;
      logic [23:0] block_tag;
      logic [7:0]  use_count;
      logic        dirty_mark;
      logic        lock_mark;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_LAST,
      S_ACC_RD,
      S_ACC_WR,
      S_DROP_RD,
      S_DROP_CHK,
      S_DROP_EMIT,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic take;
      logic acc_sel;
      logic eval;
      logic acc_write;
      logic drop_emit;
      logic final_emit;
   } cmd_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic       slot_ok;
      logic       drop_match;
      logic       out_free;
   } status_type;

endpackage

// ===== src/bpsm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bpsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/bpsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Slot manager controller
// Sequences each operation: slot scans, read-modify-write and result transfers.
// ----------------------------------------------------------------------------
module bpsm_ctrl #(
   parameter int SLOTS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  bpsm_pkg::status_type     status,
   output bpsm_pkg::cmd_type        cmd,
   output logic [$clog2(SLOTS)-1:0] idx
);
   import bpsm_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

   state_type     state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          at_last;

   assign at_last = (idx_ff == LAST_IDX);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            case (status.opcode)
               OP_LOAD, OP_ALLOC: state_in = S_SCAN;
               OP_TOUCH, OP_SET_DIRTY, OP_SET_LOCK, OP_CLR_LOCK: begin
                  state_in = status.slot_ok ? S_ACC_RD : S_EMIT;
               end
               OP_DROP: state_in = S_DROP_RD;
               default: state_in = S_EMIT;
            endcase
         end
         S_SCAN: begin
            if (at_last) state_in = S_LAST;
         end
         S_LAST:   state_in = S_EMIT;
         S_ACC_RD: state_in = S_ACC_WR;
         S_ACC_WR: state_in = S_EMIT;
         S_DROP_RD: state_in = S_DROP_CHK;
         S_DROP_CHK: begin
            if (status.drop_match) state_in = S_DROP_EMIT;
            else if (at_last) state_in = S_EMIT;
            else state_in = S_DROP_RD;
         end
         S_DROP_EMIT: begin
            if (status.out_free) state_in = at_last ? S_EMIT : S_DROP_RD;
         end
         S_EMIT: begin
            if (status.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      idx_in         = idx_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         S_DISPATCH: idx_in = '0;
         S_SCAN: begin
            cmd.eval = (idx_ff != '0);
            if (!at_last) idx_in = idx_ff + 1'b1;
         end
         S_LAST:   cmd.eval = 1'b1;
         S_ACC_RD: cmd.acc_sel = 1'b1;
         S_ACC_WR: begin
            cmd.acc_sel   = 1'b1;
            cmd.acc_write = 1'b1;
         end
         S_DROP_CHK: begin
            if (!status.drop_match && !at_last) idx_in = idx_ff + 1'b1;
         end
         S_DROP_EMIT: begin
            cmd.drop_emit = status.out_free;
            if (status.out_free && !at_last) idx_in = idx_ff + 1'b1;
         end
         S_EMIT: cmd.final_emit = status.out_free;
         default: idx_in = idx_ff;
      endcase
   end

   assign idx = idx_ff;

endmodule

// ===== src/bpsm_dp.sv =====
// ----------------------------------------------------------------------------
// Slot manager datapath
// Tag RAM, slot valid flags, scan trackers, count limit and result register.
// ----------------------------------------------------------------------------
module bpsm_dp #(
   parameter int SLOTS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  bpsm_pkg::req_type        req_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [7:0]               csr_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output bpsm_pkg::rsp_type        rsp_data,
   input  bpsm_pkg::cmd_type        cmd,
   input  logic [$clog2(SLOTS)-1:0] idx,
   output bpsm_pkg::status_type     status
);
   import bpsm_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam int EW = $bits(entry_type);

   req_type       req_ff;
   logic [7:0]    limit_ff;
   logic          valid_ff [SLOTS];
   logic [IW-1:0] rd_idx_ff;
   logic          hit_found_ff, free_found_ff, best_found_ff;
   logic [IW-1:0] hit_idx_ff, free_idx_ff, best_idx_ff;
   entry_type     best_ent_ff;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;

   logic [IW+3:0] slot_wide;
   logic          slot_ok;
   logic [IW-1:0] slot_addr;
   logic [IW-1:0] rd_addr;
   logic [EW-1:0] rd_raw;
   entry_type     entry_rd;
   logic          vld_rd, fmatch, bmatch, excluded, out_free;
   logic [IW+3:0] hit_wide, free_wide, best_wide, rd_wide;
   entry_type     acc_ent, new_ent;
   rsp_type       res, dres;
   logic          inst, clr;
   logic [IW-1:0] inst_addr;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   entry_type     wr_ent;

   assign slot_wide = {{IW{1'b0}}, req_ff.slot};
   assign slot_ok   = slot_wide < (IW + 4)'(SLOTS);
   assign slot_addr = slot_wide[IW-1:0];
   assign rd_addr   = cmd.acc_sel ? slot_addr : idx;

   bpsm_ram #(
      .WIDTH (EW),
      .DEPTH (SLOTS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ent),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign entry_rd = entry_type'(rd_raw);
   assign vld_rd   = valid_ff[rd_idx_ff];
   assign fmatch   = (entry_rd.file_tag == req_ff.file_id);
   assign bmatch   = (entry_rd.block_tag == req_ff.block_offset);
   assign excluded = (req_ff.opcode == OP_ALLOC) && req_ff.use_exclude && vld_rd && fmatch;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign hit_wide  = {4'b0000, hit_idx_ff};
   assign free_wide = {4'b0000, free_idx_ff};
   assign best_wide = {4'b0000, best_idx_ff};
   assign rd_wide   = {4'b0000, rd_idx_ff};

   assign status.opcode     = req_ff.opcode;
   assign status.slot_ok    = slot_ok;
   assign status.drop_match = vld_rd && fmatch;
   assign status.out_free   = out_free;

   always_comb begin
      acc_ent = entry_rd;
      case (req_ff.opcode)
         OP_TOUCH: begin
            if (entry_rd.use_count < limit_ff) acc_ent.use_count = entry_rd.use_count + 8'd1;
         end
         OP_SET_DIRTY: acc_ent.dirty_mark = 1'b1;
         OP_SET_LOCK:  acc_ent.lock_mark = 1'b1;
         OP_CLR_LOCK:  acc_ent.lock_mark = 1'b0;
         default:      acc_ent = entry_rd;
      endcase
   end

   always_comb begin
      new_ent              = '0;
      new_ent.file_tag     = req_ff.file_id;
      new_ent.block_tag    = req_ff.block_offset;
      new_ent.use_count    = 8'd1;
   end

   always_comb begin
      res       = '0;
      res.last  = 1'b1;
      inst      = 1'b0;
      clr       = 1'b0;
      inst_addr = free_idx_ff;
      case (req_ff.opcode)
         OP_LOAD: begin
            if (hit_found_ff) begin
               res.slot_out = hit_wide[3:0];
               res.hit      = 1'b1;
            end else if (free_found_ff) begin
               res.slot_out = free_wide[3:0];
               inst         = 1'b1;
            end else if (best_found_ff) begin
               res.slot_out = best_wide[3:0];
               inst         = 1'b1;
               inst_addr    = best_idx_ff;
               if (best_ent_ff.dirty_mark) begin
                  res.writeback       = 1'b1;
                  res.wb_file_id      = best_ent_ff.file_tag;
                  res.wb_block_offset = best_ent_ff.block_tag;
               end
            end else begin
               res.status = 1'b1;
            end
         end
         OP_ALLOC: begin
            if (free_found_ff) begin
               res.slot_out = free_wide[3:0];
            end else if (best_found_ff) begin
               res.slot_out = best_wide[3:0];
               clr          = 1'b1;
               if (best_ent_ff.dirty_mark) begin
                  res.writeback       = 1'b1;
                  res.wb_file_id      = best_ent_ff.file_tag;
                  res.wb_block_offset = best_ent_ff.block_tag;
               end
            end else begin
               res.status = 1'b1;
            end
         end
         OP_TOUCH, OP_SET_DIRTY, OP_SET_LOCK, OP_CLR_LOCK: begin
            res.slot_out = req_ff.slot;
            res.status   = !slot_ok;
         end
         OP_DROP: res.status = 1'b0;
         default: res.status = 1'b1;
      endcase
   end

   always_comb begin
      dres          = '0;
      dres.slot_out = rd_wide[3:0];
      if (entry_rd.dirty_mark) begin
         dres.writeback       = 1'b1;
         dres.wb_file_id      = entry_rd.file_tag;
         dres.wb_block_offset = entry_rd.block_tag;
      end
   end

   always_comb begin
      if (cmd.acc_write) begin
         wr_en   = 1'b1;
         wr_addr = slot_addr;
         wr_ent  = acc_ent;
      end else begin
         wr_en   = cmd.final_emit && inst;
         wr_addr = inst_addr;
         wr_ent  = new_ent;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_addr;
      if (cmd.take) begin
         req_ff <= req_data;
      end
      if (cmd.eval) begin
         if (!free_found_ff && !vld_rd) free_idx_ff <= rd_idx_ff;
         if (!hit_found_ff) hit_idx_ff <= rd_idx_ff;
         if (vld_rd && !excluded && !entry_rd.lock_mark &&
             (!best_found_ff || entry_rd.use_count <= best_ent_ff.use_count)) begin
            best_idx_ff <= rd_idx_ff;
            best_ent_ff <= entry_rd;
         end
      end
      if (cmd.drop_emit) begin
         rsp_ff <= dres;
      end else if (cmd.final_emit) begin
         rsp_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         best_found_ff <= 1'b0;
      end else if (cmd.take) begin
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         best_found_ff <= 1'b0;
      end else if (cmd.eval) begin
         if (!vld_rd) free_found_ff <= 1'b1;
         if ((req_ff.opcode == OP_LOAD) && vld_rd && fmatch && bmatch) hit_found_ff <= 1'b1;
         if (vld_rd && !excluded && !entry_rd.lock_mark) best_found_ff <= 1'b1;
      end
   end

   // The hit index only latches while no hit has been seen, so it must not move after one.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         if (cmd.final_emit && inst) valid_ff[inst_addr] <= 1'b1;
         if (cmd.final_emit && clr) valid_ff[best_idx_ff] <= 1'b0;
         if (cmd.drop_emit) valid_ff[rd_idx_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= COUNT_LIMIT_RESET;
      end else if (csr_valid) begin
         limit_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.drop_emit || cmd.final_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.drop_emit || cmd.final_emit) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded while the output register is occupied");

   a_single_write: assert property (@(posedge clock) disable iff (reset)
      cmd.acc_write |-> (!cmd.final_emit && !cmd.drop_emit))
      else $error("tag RAM write collision");

   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.hit) |-> (!rsp_ff.status && !rsp_ff.writeback && rsp_ff.last))
      else $error("hit result carries status or write-back");

   a_wb_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.writeback) |->
         (rsp_ff.wb_file_id == '0 && rsp_ff.wb_block_offset == '0))
      else $error("write-back tag not zero without write-back");
`endif

endmodule

// ===== src/buffer_pool_slot_manager_unit.sv =====
// ----------------------------------------------------------------------------
// Buffer pool slot manager
// Tag table of buffer slots with least-frequently-used replacement.
// ----------------------------------------------------------------------------
// Each request runs alone through the single read port of the tag RAM; load
// and allocate scan one slot per cycle. Touch, dirty and lock operations read,
// modify and write their slot, or go straight to the result for a slot out of
// range or an unused opcode. Drop-file reads and checks each slot in turn. Each
// result waits for a free output register; a new request is accepted while the
// last result still waits in the output register. Slot valid flags are cleared
// by reset at once, so no clearing pass follows reset.
module buffer_pool_slot_manager_unit #(
   parameter int SLOTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bpsm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bpsm_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_data
);
   import bpsm_pkg::*;

   localparam int IW = $clog2(SLOTS);

   cmd_type       cmd;
   status_type    status;
   logic [IW-1:0] idx;

   bpsm_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd),
      .idx       (idx)
   );

   bpsm_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .idx       (idx),
      .status    (status)
   );

endmodule

// ===== bench/bpsm_checker.sv =====
// ----------------------------------------------------------------------------
// Buffer pool slot manager checker
// Watches the request, result and register channels of the slot manager. It
// keeps its own copy of the slot table and the count limit, works out the
// results of every accepted request, and compares each result transfer
// field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module bpsm_checker
   import bpsm_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  rsp_type    rsp_data,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [7:0] csr_data,
   output int         error_count,
   output int         pending_count,
   output int         result_count,
   output int         writeback_count
);

   logic        slot_used [SLOTS];
   logic [15:0] file_of   [SLOTS];
   logic [23:0] block_of  [SLOTS];
   logic [7:0]  uses      [SLOTS];
   logic        dirty     [SLOTS];
   logic        locked    [SLOTS];
   logic [7:0]  limit;
   rsp_type     slot_reports [$];

   task automatic clear_entry(input int i);
      slot_used[i] = 1'b0;
      file_of[i] = '0;
      block_of[i] = '0;
      uses[i] = '0;
      dirty[i] = 1'b0;
      locked[i] = 1'b0;
   endtask

   task automatic clear_table();
      int i;
      for (i = 0; i < SLOTS; i++) clear_entry(i);
      limit = COUNT_LIMIT_RESET;
   endtask

   function automatic rsp_type slot_report(input int slot, input logic hit,
                                           input logic status, input int wb_slot,
                                           input logic last);
      rsp_type r;
      r.slot_out = 4'(slot);
      r.hit = hit;
      r.status = status;
      r.writeback = 1'b0;
      r.wb_file_id = '0;
      r.wb_block_offset = '0;
      if (wb_slot >= 0 && dirty[wb_slot]) begin
         r.writeback = 1'b1;
         r.wb_file_id = file_of[wb_slot];
         r.wb_block_offset = block_of[wb_slot];
      end
      r.last = last;
      return r;
   endfunction

   // Free slot first; otherwise the unlocked slot with the lowest count,
   // the highest index winning ties.
   function automatic int pick_slot(input logic excl, input logic [15:0] fid,
                                    output logic evicted);
      int i;
      int best;
      int lowest;
      best = -1;
      lowest = 256;
      evicted = 1'b0;
      for (i = 0; i < SLOTS; i++) begin
         if (excl && slot_used[i] && file_of[i] == fid) continue;
         if (!slot_used[i]) return i;
         if (!locked[i] && int'(uses[i]) <= lowest) begin
            lowest = uses[i];
            best = i;
         end
      end
      evicted = (best >= 0);
      return best;
   endfunction

   task automatic apply_request(input req_type r);
      int i;
      int idx;
      logic evicted;
      case (r.opcode)
         OP_LOAD: begin
            idx = -1;
            for (i = 0; i < SLOTS; i++) begin
               if (idx < 0 && slot_used[i] && file_of[i] == r.file_id &&
                   block_of[i] == r.block_offset) idx = i;
            end
            if (idx >= 0) begin
               slot_reports.push_back(slot_report(idx, 1'b1, 1'b0, -1, 1'b1));
            end else begin
               idx = pick_slot(1'b0, r.file_id, evicted);
               if (idx < 0) begin
                  slot_reports.push_back(slot_report(0, 1'b0, 1'b1, -1, 1'b1));
               end else begin
                  slot_reports.push_back(slot_report(idx, 1'b0, 1'b0,
                                                     evicted ? idx : -1, 1'b1));
                  clear_entry(idx);
                  slot_used[idx] = 1'b1;
                  file_of[idx] = r.file_id;
                  block_of[idx] = r.block_offset;
                  uses[idx] = 8'd1;
               end
            end
         end
         OP_TOUCH, OP_SET_DIRTY, OP_SET_LOCK, OP_CLR_LOCK: begin
            if (int'(r.slot) >= SLOTS) begin
               slot_reports.push_back(slot_report(r.slot, 1'b0, 1'b1, -1, 1'b1));
            end else begin
               case (r.opcode)
                  OP_TOUCH: begin
                     if (uses[r.slot] < limit) uses[r.slot] = uses[r.slot] + 8'd1;
                  end
                  OP_SET_DIRTY: dirty[r.slot] = 1'b1;
                  OP_SET_LOCK:  locked[r.slot] = 1'b1;
                  default:      locked[r.slot] = 1'b0;
               endcase
               slot_reports.push_back(slot_report(r.slot, 1'b0, 1'b0, -1, 1'b1));
            end
         end
         OP_DROP: begin
            for (i = 0; i < SLOTS; i++) begin
               if (slot_used[i] && file_of[i] == r.file_id) begin
                  slot_reports.push_back(slot_report(i, 1'b0, 1'b0, i, 1'b0));
                  clear_entry(i);
               end
            end
            slot_reports.push_back(slot_report(0, 1'b0, 1'b0, -1, 1'b1));
         end
         OP_ALLOC: begin
            idx = pick_slot(r.use_exclude, r.file_id, evicted);
            if (idx < 0) begin
               slot_reports.push_back(slot_report(0, 1'b0, 1'b1, -1, 1'b1));
            end else begin
               slot_reports.push_back(slot_report(idx, 1'b0, 1'b0,
                                                  evicted ? idx : -1, 1'b1));
               if (evicted) clear_entry(idx);
            end
         end
         default: begin
            slot_reports.push_back(slot_report(0, 1'b0, 1'b1, -1, 1'b1));
         end
      endcase
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      result_count++;
      if (got.writeback === 1'b1) writeback_count++;
      if (slot_reports.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display("ERROR: result transfer with nothing expected: slot=%0d hit=%b status=%b",
                     got.slot_out, got.hit, got.status);
         return;
      end
      want = slot_reports.pop_front();
      if (got.slot_out !== want.slot_out || got.hit !== want.hit ||
          got.status !== want.status || got.writeback !== want.writeback ||
          got.wb_file_id !== want.wb_file_id ||
          got.wb_block_offset !== want.wb_block_offset || got.last !== want.last) begin
         error_count++;
         if (error_count <= 10) begin
            $display("ERROR: result %0d differs from the expected transfer", result_count);
            $display("       expected slot=%0d hit=%b status=%b wb=%b file=%h",
                     want.slot_out, want.hit, want.status, want.writeback, want.wb_file_id);
            $display("                block=%h last=%b", want.wb_block_offset, want.last);
            $display("       got      slot=%0d hit=%b status=%b wb=%b file=%h",
                     got.slot_out, got.hit, got.status, got.writeback, got.wb_file_id);
            $display("                block=%h last=%b", got.wb_block_offset, got.last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_table();
         slot_reports.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_result(rsp_data);
         if (csr_valid && csr_ready) limit = csr_data;
         if (req_valid && req_ready) apply_request(req_data);
      end
      pending_count = slot_reports.size();
   end

endmodule

// ===== bench/buffer_pool_slot_manager_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Buffer pool slot manager testbench
// Drives directed and random request sequences into the slot manager under
// several count limits and idling patterns, while a checker beside the block
// predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module buffer_pool_slot_manager_unit_tb;
   import bpsm_pkg::*;

   localparam int SLOTS = 16;
   localparam logic [2:0] OP_UNUSED = 3'd7;
   localparam int RUN_LIMIT = 400000;
   localparam int ITEMS_PER_PHASE = 95;
   localparam int DRAIN_CYCLES = 3 * SLOTS + 40;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_ready;
   rsp_type    rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic [7:0] csr_data;

   int error_count;
   int pending_count;
   int result_count;
   int writeback_count;
   int idle_pct = 0;
   int stall_pct = 0;
   int sent_count = 0;
   int cycle_count;
   int phase;
   int phase_start;

   logic [15:0] file_pool [4] = '{16'h0000, 16'hFFFF, 16'h5A3C, 16'h0001};
   logic [7:0]  phase_limit [4] = '{8'd255, 8'd1, 8'd0, 8'd100};
   int          phase_idle  [4] = '{0, 56, 0, 35};
   int          phase_stall [4] = '{0, 0, 56, 35};

   buffer_pool_slot_manager_unit #(
      .SLOTS(SLOTS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   bpsm_checker #(
      .SLOTS(SLOTS)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data),
      .error_count(error_count),
      .pending_count(pending_count),
      .result_count(result_count),
      .writeback_count(writeback_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   function automatic req_type make_req(input logic [2:0] op, input logic [15:0] fid,
                                        input logic [23:0] blk, input logic [3:0] slot,
                                        input logic excl);
      req_type r;
      r.opcode = op;
      r.file_id = fid;
      r.block_offset = blk;
      r.slot = slot;
      r.use_exclude = excl;
      return r;
   endfunction

   function automatic logic [15:0] pick_file();
      if ($urandom_range(9) == 0) return 16'($urandom);
      return file_pool[$urandom_range(3)];
   endfunction

   function automatic logic [23:0] pick_block();
      if ($urandom_range(9) == 0) return 24'($urandom);
      return 24'($urandom_range(5));
   endfunction

   task automatic send(input req_type r);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      sent_count++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   task automatic write_limit(input logic [7:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_op();
      int pick;
      logic [2:0] op;
      pick = $urandom_range(99);
      if (pick < 36) op = OP_LOAD;
      else if (pick < 52) op = OP_TOUCH;
      else if (pick < 63) op = OP_SET_DIRTY;
      else if (pick < 72) op = OP_SET_LOCK;
      else if (pick < 82) op = OP_CLR_LOCK;
      else if (pick < 88) op = OP_DROP;
      else if (pick < 97) op = OP_ALLOC;
      else op = OP_UNUSED;
      send(make_req(op, pick_file(), pick_block(), 4'($urandom), 1'($urandom)));
   endtask

   // Fills the table with one file, locks every slot so that nothing can be
   // taken, then unlocks, marks some slots dirty and drops the whole file.
   task automatic lock_sweep();
      logic [15:0] fid;
      int i;
      fid = pick_file();
      for (i = 0; i < SLOTS; i++)
         send(make_req(OP_LOAD, fid, {8'($urandom), 16'(i * 8 + $urandom_range(7))},
                       4'($urandom), 1'($urandom)));
      for (i = 0; i < SLOTS; i++)
         send(make_req(OP_SET_LOCK, pick_file(), pick_block(), 4'(i), 1'($urandom)));
      send(make_req(OP_LOAD, fid, 24'hFFFFFF, 4'($urandom), 1'($urandom)));
      send(make_req(OP_ALLOC, fid, pick_block(), 4'($urandom), 1'b1));
      send(make_req(OP_ALLOC, pick_file(), pick_block(), 4'($urandom), 1'b0));
      for (i = SLOTS - 1; i >= 0; i--)
         send(make_req(OP_CLR_LOCK, pick_file(), pick_block(), 4'(i), 1'($urandom)));
      for (i = 0; i < SLOTS; i++) begin
         if ($urandom_range(3) != 0)
            send(make_req(OP_SET_DIRTY, pick_file(), pick_block(), 4'(i), 1'($urandom)));
      end
      send(make_req(OP_DROP, fid, pick_block(), 4'($urandom), 1'($urandom)));
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_limit(8'd2);
      send(make_req(OP_DROP, 16'h0000, 24'h000000, 4'd0, 1'b0));
      send(make_req(OP_UNUSED, 16'hFFFF, 24'hFFFFFF, 4'hF, 1'b1));
      send(make_req(OP_LOAD, 16'h0000, 24'h000000, 4'd0, 1'b0));
      send(make_req(OP_LOAD, 16'hFFFF, 24'hFFFFFF, 4'd0, 1'b0));
      send(make_req(OP_LOAD, 16'hFFFF, 24'hFFFFFF, 4'd0, 1'b0));
      repeat (3) send(make_req(OP_TOUCH, 16'h0000, 24'h000000, 4'd1, 1'b0));
      send(make_req(OP_TOUCH, 16'h0000, 24'h000000, 4'd15, 1'b0));
      send(make_req(OP_SET_DIRTY, 16'h0000, 24'h000000, 4'd1, 1'b0));
      send(make_req(OP_SET_DIRTY, 16'h0000, 24'h000000, 4'd15, 1'b0));
      send(make_req(OP_SET_LOCK, 16'h0000, 24'h000000, 4'd0, 1'b0));
      send(make_req(OP_ALLOC, 16'h0000, 24'h000000, 4'd0, 1'b1));
      send(make_req(OP_CLR_LOCK, 16'h0000, 24'h000000, 4'd0, 1'b0));
      send(make_req(OP_DROP, 16'hFFFF, 24'h000000, 4'd0, 1'b0));
      send(make_req(OP_LOAD, 16'h1234, 24'h5A5A5A, 4'd0, 1'b0));

      for (phase = 0; phase < 4; phase++) begin
         write_limit(phase_limit[phase]);
         idle_pct = phase_idle[phase];
         stall_pct = phase_stall[phase];
         phase_start = sent_count;
         if (phase % 2 == 0) lock_sweep();
         while (sent_count - phase_start < ITEMS_PER_PHASE) begin
            if ($urandom_range(24) == 0) drain();
            random_op();
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Summary: %0d requests under count limits 2, 255, 1, 0 and 100, with idle",
               sent_count);
      $display("Summary: and stall mixes; %0d results checked, %0d of them write-backs.",
               result_count, writeback_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
